/* rtl/sss_pkg.sv */
// ----------------------------------------------------------------------------
// sss_pkg: shared types and constants of the servo sweep sequencer
// Item structs, register indexes, reset values and the angle-to-duty table.
// ----------------------------------------------------------------------------
package sss_pkg;

  localparam int unsigned ANGLE_W    = 8;
  localparam int unsigned DUTY_W     = 10;
  localparam int unsigned ELAPSED_W  = 6;
  localparam int unsigned PHASE_W    = 2;
  localparam int unsigned TIMER_W    = 16;
  localparam int unsigned SWEEP_W    = 17;
  localparam int unsigned HOLD_W     = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // serial arithmetic: span is the multiplier, products and dividends are 24 bits
  localparam int unsigned PROD_W    = ANGLE_W + TIMER_W;
  localparam int unsigned STEP_W    = 5;
  localparam int unsigned MUL_STEPS = ANGLE_W;
  localparam int unsigned DIV_STEPS = PROD_W;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX = ANGLE_W'(180);
  localparam logic [ANGLE_W-1:0] ANGLE_MID = ANGLE_W'(90);

  localparam logic [SWEEP_W-1:0] SWEEP_TIME_MAX = {SWEEP_W{1'b1}};
  localparam logic [TIMER_W-1:0] TIMER_MAX      = {TIMER_W{1'b1}};

  // sweep phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE  = PHASE_W'(0);
  localparam logic [PHASE_W-1:0] PH_SWEEP = PHASE_W'(1);
  localparam logic [PHASE_W-1:0] PH_DWELL = PHASE_W'(2);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ONE_WAY     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_END_REST    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DETACH      = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_START_DELAY = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_HOLD        = CFG_IDX_W'(4);

  localparam logic [TIMER_W-1:0] ONE_WAY_RST     = TIMER_W'(3000);
  localparam logic [TIMER_W-1:0] END_REST_RST    = TIMER_W'(3000);
  localparam logic [TIMER_W-1:0] DETACH_RST      = TIMER_W'(1000);
  localparam logic [TIMER_W-1:0] START_DELAY_RST = TIMER_W'(5000);
  localparam logic [HOLD_W-1:0]  HOLD_RST        = HOLD_W'(60);

  typedef struct packed {
    logic [ELAPSED_W-1:0] elapsed_ms;
    logic                 vehicle_moving;
  } in_item_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle_deg;
    logic [DUTY_W-1:0]  pulse_duty;
    logic               servo_attached;
    logic [PHASE_W-1:0] sweep_phase;
  } out_item_t;

  typedef logic [255:0][DUTY_W-1:0] duty_tab_t;

  // pulse width 500..2500 us over 0..180 degrees, as a 10-bit duty of a 20 ms frame
  function automatic duty_tab_t build_duty_tab();
    duty_tab_t tab;
    int unsigned deg;
    int unsigned us;
    for (int i = 0; i < 256; i++) begin
      deg = (i > 180) ? 180 : i;
      us = 500 + (2000 * deg) / 180;
      tab[i] = DUTY_W'((us * 50 * 1023) / 1000000);
    end
    return tab;
  endfunction

  localparam duty_tab_t DUTY_TAB = build_duty_tab();

  function automatic logic [ANGLE_W-1:0] far_end(input logic [ANGLE_W-1:0] deg);
    return (deg >= ANGLE_MID) ? '0 : ANGLE_MAX;
  endfunction

endpackage

/* rtl/servo_sweep_sequencer.sv */
// ----------------------------------------------------------------------------
// servo_sweep_sequencer: radar servo sweep control
// Phase, timer and attach logic with a bit-serial multiplier and divider
// that interpolate the sweep angle.
// ----------------------------------------------------------------------------
// Sequence: outside the interpolating part of a sweep an accepted item goes straight to the
//   finish state; while interpolating it runs one 8-step multiply and one 24-step divide
//   for the duration, then the same for the step; only the first pair runs when the sweep
//   has reached its time. Items go one at a time: input stalls until the result register
//   is loaded, and a stalled result holds off the next item.
// Reset: synchronous, clears all sequencing state and loads the register defaults.
module servo_sweep_sequencer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  sss_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output sss_pkg::out_item_t                   out_data,
  input  logic                                 cfg_we,
  input  logic [sss_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sss_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  localparam logic [sss_pkg::PHASE_W-1:0] PH_IDLE  = sss_pkg::PH_IDLE;
  localparam logic [sss_pkg::PHASE_W-1:0] PH_SWEEP = sss_pkg::PH_SWEEP;
  localparam logic [sss_pkg::PHASE_W-1:0] PH_DWELL = sss_pkg::PH_DWELL;

  localparam int unsigned AW = sss_pkg::ANGLE_W;
  localparam int unsigned TW = sss_pkg::TIMER_W;
  localparam int unsigned SW = sss_pkg::SWEEP_W;
  localparam int unsigned PW = sss_pkg::PROD_W;

  // configuration
  logic [TW-1:0] one_way_ms, end_rest_ms, detach_ms, start_delay_ms;
  logic [sss_pkg::HOLD_W-1:0] hold_ms;

  // sequencing state
  logic [1:0]                   st;
  logic [sss_pkg::PHASE_W-1:0]  phase;
  logic [AW-1:0]                current_angle, start_angle, target_angle;
  logic [SW-1:0]                sweep_time;
  logic [TW-1:0]                dwell_time, since_stopped;
  logic                         need_start_delay, attached, was_moving;

  // serial arithmetic
  logic                         pass;
  logic [sss_pkg::STEP_W-1:0]   cnt;
  logic [PW-1:0]                acc;
  logic [TW-1:0]                mcand;
  logic [AW-1:0]                mpl;
  logic [TW-1:0]                rem;
  logic [PW-1:0]                divq;
  logic [TW-1:0]                dur;
  logic [SW-1:0]                t_rel;

  // next values for an accepted item
  logic [sss_pkg::PHASE_W-1:0]  phase_next;
  logic [AW-1:0]                current_angle_next, start_angle_next, target_angle_next;
  logic [SW-1:0]                sweep_time_next, t_rel_next;
  logic [TW-1:0]                dwell_time_next, since_stopped_next;
  logic                         need_start_delay_next, attached_next, was_moving_next;
  logic                         go_arith, launch, delay_ok;
  logic [AW-1:0]                tgt_base;
  logic [SW:0]                  sw_sum;
  logic [TW:0]                  dw_sum, ss_sum;

  logic                         in_acc;
  logic                         down;
  logic [AW-1:0]                span;
  logic [PW-1:0]                acc_next;
  logic [TW:0]                  rem_sh;
  logic [TW-1:0]                divisor;
  logic                         q_bit;
  logic [PW-1:0]                divq_next;
  logic [TW-1:0]                rem_next;
  logic                         out_free;

  assign in_stall = (st != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign down = (target_angle < start_angle);
  assign span = down ? (start_angle - target_angle) : (target_angle - start_angle);

  always_comb begin
    sw_sum = {1'b0, sweep_time} + (SW + 1)'(in_data.elapsed_ms);
    dw_sum = {1'b0, dwell_time} + (TW + 1)'(in_data.elapsed_ms);
    ss_sum = {1'b0, since_stopped} + (TW + 1)'(in_data.elapsed_ms);
    sweep_time_next    = sw_sum[SW] ? sss_pkg::SWEEP_TIME_MAX : sw_sum[SW-1:0];
    dwell_time_next    = dw_sum[TW] ? sss_pkg::TIMER_MAX : dw_sum[TW-1:0];
    since_stopped_next = ss_sum[TW] ? sss_pkg::TIMER_MAX : ss_sum[TW-1:0];

    was_moving_next       = was_moving;
    need_start_delay_next = need_start_delay;
    if (in_data.vehicle_moving != was_moving) begin
      was_moving_next = in_data.vehicle_moving;
      if (!in_data.vehicle_moving) begin
        since_stopped_next    = '0;
        need_start_delay_next = 1'b1;
      end
    end

    phase_next         = phase;
    current_angle_next = current_angle;
    start_angle_next   = start_angle;
    target_angle_next  = target_angle;
    attached_next      = attached;
    go_arith           = 1'b0;
    launch             = 1'b0;
    tgt_base           = target_angle;
    t_rel_next         = sweep_time_next - SW'(hold_ms);
    delay_ok = !need_start_delay_next ||
               (!in_data.vehicle_moving && (since_stopped_next >= start_delay_ms));

    unique case (phase)
      PH_SWEEP: begin
        if (sweep_time_next >= SW'(hold_ms)) begin
          go_arith = 1'b1;
        end else begin
          current_angle_next = start_angle;
        end
      end
      PH_DWELL: begin
        if (attached && (dwell_time_next >= detach_ms)) begin
          attached_next = 1'b0;
        end
        if (!in_data.vehicle_moving && (dwell_time_next >= end_rest_ms) && delay_ok) begin
          launch   = 1'b1;
          tgt_base = sss_pkg::far_end(current_angle);
        end
      end
      default: begin
        phase_next    = PH_IDLE;
        attached_next = 1'b0;
        if (delay_ok) begin
          launch = 1'b1;
        end
      end
    endcase

    if (launch) begin
      need_start_delay_next = 1'b0;
      start_angle_next      = current_angle;
      target_angle_next     = (current_angle == tgt_base) ?
                              sss_pkg::far_end(current_angle) : tgt_base;
      attached_next         = 1'b1;
      sweep_time_next       = '0;
      phase_next            = PH_SWEEP;
    end
  end

  // shift-add multiplier, multiplier bits msb first
  assign acc_next = {acc[PW-2:0], 1'b0} + (mpl[AW-1] ? PW'(mcand) : '0);

  // restoring divider, one quotient bit per cycle
  assign divisor   = pass ? dur : TW'(sss_pkg::ANGLE_MAX);
  assign rem_sh    = {rem, divq[PW-1]};
  assign q_bit     = (rem_sh >= {1'b0, divisor});
  assign rem_next  = q_bit ? TW'(rem_sh - {1'b0, divisor}) : rem_sh[TW-1:0];
  assign divq_next = {divq[PW-2:0], q_bit};

  always_ff @(posedge clk) begin
    if (rst) begin
      one_way_ms       <= sss_pkg::ONE_WAY_RST;
      end_rest_ms      <= sss_pkg::END_REST_RST;
      detach_ms        <= sss_pkg::DETACH_RST;
      start_delay_ms   <= sss_pkg::START_DELAY_RST;
      hold_ms          <= sss_pkg::HOLD_RST;
      st               <= S_IDLE;
      out_valid        <= 1'b0;
      phase            <= PH_IDLE;
      current_angle    <= '0;
      start_angle      <= '0;
      target_angle     <= sss_pkg::ANGLE_MAX;
      sweep_time       <= '0;
      dwell_time       <= '0;
      since_stopped    <= '0;
      need_start_delay <= 1'b1;
      attached         <= 1'b0;
      was_moving       <= 1'b0;
      pass             <= 1'b0;
      cnt              <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sss_pkg::REG_ONE_WAY:     one_way_ms     <= cfg_data;
          sss_pkg::REG_END_REST:    end_rest_ms    <= cfg_data;
          sss_pkg::REG_DETACH:      detach_ms      <= cfg_data;
          sss_pkg::REG_START_DELAY: start_delay_ms <= cfg_data;
          sss_pkg::REG_HOLD:        hold_ms        <= cfg_data[sss_pkg::HOLD_W-1:0];
          default: ;
        endcase
      end

      if ((st == S_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (st)
        S_IDLE: begin
          if (in_acc) begin
            phase            <= phase_next;
            current_angle    <= current_angle_next;
            start_angle      <= start_angle_next;
            target_angle     <= target_angle_next;
            sweep_time       <= sweep_time_next;
            dwell_time       <= dwell_time_next;
            since_stopped    <= since_stopped_next;
            need_start_delay <= need_start_delay_next;
            attached         <= attached_next;
            was_moving       <= was_moving_next;
            t_rel            <= t_rel_next;
            if (go_arith) begin
              // duration = span * one_way_ms / 180
              pass  <= 1'b0;
              cnt   <= '0;
              acc   <= '0;
              mcand <= one_way_ms;
              mpl   <= span;
              st    <= S_MUL;
            end else begin
              st <= S_FIN;
            end
          end
        end
        S_MUL: begin
          acc <= acc_next;
          mpl <= {mpl[AW-2:0], 1'b0};
          if (cnt == sss_pkg::STEP_W'(sss_pkg::MUL_STEPS - 1)) begin
            cnt  <= '0;
            rem  <= '0;
            divq <= acc_next;
            st   <= S_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DIV: begin
          rem  <= rem_next;
          divq <= divq_next;
          if (cnt == sss_pkg::STEP_W'(sss_pkg::DIV_STEPS - 1)) begin
            cnt <= '0;
            if (!pass) begin
              dur <= divq_next[TW-1:0];
              if ((divq_next[TW-1:0] == '0) || (t_rel >= SW'(divq_next[TW-1:0]))) begin
                // sweep time is up: arrive at the target
                current_angle <= target_angle;
                attached      <= 1'b1;
                phase         <= PH_DWELL;
                dwell_time    <= '0;
                st            <= S_FIN;
              end else begin
                // step = span * t / duration, t below duration fits 16 bits
                pass  <= 1'b1;
                acc   <= '0;
                mcand <= t_rel[TW-1:0];
                mpl   <= span;
                st    <= S_MUL;
              end
            end else begin
              current_angle <= down ? (start_angle - divq_next[AW-1:0])
                                    : (start_angle + divq_next[AW-1:0]);
              attached <= 1'b1;
              if ((down ? (start_angle - divq_next[AW-1:0])
                        : (start_angle + divq_next[AW-1:0])) == target_angle) begin
                phase      <= PH_DWELL;
                dwell_time <= '0;
              end
              st <= S_FIN;
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_FIN: begin
          if (out_free) begin
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // result register, loaded as the item finishes
  always_ff @(posedge clk) begin
    if ((st == S_FIN) && out_free) begin
      out_data.angle_deg      <= current_angle;
      out_data.pulse_duty     <= sss_pkg::DUTY_TAB[current_angle];
      out_data.servo_attached <= attached;
      out_data.sweep_phase    <= phase;
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (st != S_IDLE))
    else $error("accepted item did not start processing");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(st) == S_FIN))
    else $error("result appeared without a finished item");

  a_idle_released: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.sweep_phase == PH_IDLE)) |-> !out_data.servo_attached)
    else $error("servo attached while idle");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.angle_deg <= sss_pkg::ANGLE_MAX))
    else $error("angle beyond 180 degrees");

  a_sweep_attached: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.sweep_phase == PH_SWEEP)) |-> out_data.servo_attached)
    else $error("servo released during a sweep");
`endif

endmodule

/* tb/tb_servo_sweep_sequencer.sv */
// ----------------------------------------------------------------------------
// tb_servo_sweep_sequencer: self-checking bench for the servo sweep sequencer
// A short scripted run walks reset, launch, arrival, hold and register edge
// cases, then randomized runs under several register settings (slow sweep with
// maximum hold and rest, zero timers with a 1 ms one-way time, small random timers, defaults) check
// every result against a cycle-free model of the sweep, with random gaps and
// output stalls.
// ----------------------------------------------------------------------------
module tb_servo_sweep_sequencer;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned N_SETTINGS  = 7;

  typedef enum logic [sss_pkg::PHASE_W-1:0] {
    ST_IDLE  = sss_pkg::PH_IDLE,
    ST_SWEEP = sss_pkg::PH_SWEEP,
    ST_DWELL = sss_pkg::PH_DWELL
  } sweep_phase_e;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

  localparam logic [sss_pkg::CFG_IDX_W-1:0] REG_UNUSED = sss_pkg::CFG_IDX_W'(7);
  localparam logic [sss_pkg::DUTY_W-1:0]    DUTY_AT_0   = 10'd25;
  localparam logic [sss_pkg::DUTY_W-1:0]    DUTY_AT_180 = 10'd127;
  localparam sss_pkg::out_item_t            NO_CHECK    = '0;

  typedef struct packed {
    row_kind_e                          kind;
    logic [sss_pkg::CFG_IDX_W-1:0]      reg_idx;
    logic [sss_pkg::CFG_DATA_W-1:0]     reg_val;
    logic [sss_pkg::ELAPSED_W-1:0]      elapsed;
    logic                               moving;
    logic                               typed;
    sss_pkg::out_item_t                 want;
  } script_row_t;

  // kind, register, value, elapsed, moving, typed result, result
  localparam int unsigned SCRIPT_LEN = 28;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{ROW_ITEM, sss_pkg::REG_ONE_WAY, 16'd0, 6'd0, 1'b0, 1'b1,
      '{8'd0, DUTY_AT_0, 1'b0, ST_IDLE}},
    '{ROW_ITEM, sss_pkg::REG_ONE_WAY, 16'd0, 6'd63, 1'b1, 1'b1,
      '{8'd0, DUTY_AT_0, 1'b0, ST_IDLE}},
    '{ROW_ITEM, sss_pkg::REG_ONE_WAY, 16'd0, 6'h2A, 1'b0, 1'b1,
      '{8'd0, DUTY_AT_0, 1'b0, ST_IDLE}},
    '{ROW_REG, sss_pkg::REG_START_DELAY, 16'd0, 6'd0, 1'b0, 1'b0, NO_CHECK},
    '{ROW_REG, sss_pkg::REG_HOLD, 16'd0, 6'd0, 1'b0, 1'b0, NO_CHECK},
    '{ROW_REG, sss_pkg::REG_ONE_WAY, 16'd1, 6'd0, 1'b0, 1'b0, NO_CHECK},
    '{ROW_ITEM, sss_pkg::REG_ONE_WAY, 16'd0, 6'd0, 1'b0, 1'b1,
      '{8'd0, DUTY_AT_0, 1'b1, ST_SWEEP}},
    '{ROW_ITEM, sss_pkg::REG_ONE_WAY, 16'd0, 6'd63, 1'b0, 1'b1,
      '{8'd180, DUTY_AT_180, 1'b1, ST_DWELL}},
    '{ROW_REG, sss_pkg::REG_DETACH, 16'd0, 6'd0, 1'b0, 1'b0, NO_CHECK},
    '{ROW_REG, sss_pkg::REG_END_REST, 16'd0, 6'd0, 1'b0, 1'b0, NO_CHECK},
    '{ROW_REG, sss_pkg::REG_ONE_WAY, 16'hFFFF, 6'd0, 1'b0, 1'b0, NO_CHECK},
    '{ROW_ITEM, sss_pkg::REG_ONE_WAY, 16'd0, 6'd0, 1'b0, 1'b1,
      '{8'd180, DUTY_AT_180, 1'b1, ST_SWEEP}},
    '{ROW_ITEM, sss_pkg::REG_ONE_WAY, 16'd0, 6'd63, 1'b0, 1'b0, NO_CHECK},
    '{ROW_ITEM, sss_pkg::REG_ONE_WAY, 16'd0, 6'h15, 1'b1, 1'b0, NO_CHECK},
    '{ROW_ITEM, sss_pkg::REG_ONE_WAY, 16'd0, 6'd0, 1'b0, 1'b0, NO_CHECK},
    // shortest sweep: arrives as soon as the next item comes in
    '{ROW_REG, sss_pkg::REG_ONE_WAY, 16'd1, 6'd0, 1'b0, 1'b0, NO_CHECK},
    '{ROW_ITEM, sss_pkg::REG_ONE_WAY, 16'd0, 6'd1, 1'b0, 1'b0, NO_CHECK},
    '{ROW_ITEM, sss_pkg::REG_ONE_WAY, 16'd0, 6'd0, 1'b0, 1'b0, NO_CHECK},
    // upper bits of the hold value are dropped, leaving 64 ms
    '{ROW_REG, sss_pkg::REG_HOLD, 16'hFC40, 6'd0, 1'b0, 1'b0, NO_CHECK},
    '{ROW_ITEM, sss_pkg::REG_ONE_WAY, 16'd0, 6'd63, 1'b0, 1'b0, NO_CHECK},
    '{ROW_REG, sss_pkg::REG_ONE_WAY, 16'd0, 6'd0, 1'b0, 1'b0, NO_CHECK},
    '{ROW_ITEM, sss_pkg::REG_ONE_WAY, 16'd0, 6'd1, 1'b0, 1'b0, NO_CHECK},
    '{ROW_REG, sss_pkg::REG_START_DELAY, 16'hFFFF, 6'd0, 1'b0, 1'b0, NO_CHECK},
    '{ROW_REG, sss_pkg::REG_DETACH, 16'hFFFF, 6'd0, 1'b0, 1'b0, NO_CHECK},
    '{ROW_ITEM, sss_pkg::REG_ONE_WAY, 16'd0, 6'd63, 1'b1, 1'b0, NO_CHECK},
    '{ROW_ITEM, sss_pkg::REG_ONE_WAY, 16'd0, 6'd0, 1'b0, 1'b0, NO_CHECK},
    '{ROW_REG, REG_UNUSED, 16'hFFFF, 6'd0, 1'b0, 1'b0, NO_CHECK},
    '{ROW_ITEM, sss_pkg::REG_ONE_WAY, 16'd0, 6'd63, 1'b0, 1'b0, NO_CHECK}
  };

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  sss_pkg::in_item_t              in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  sss_pkg::out_item_t             out_data;
  logic                           cfg_we = 1'b0;
  logic [sss_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sss_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  servo_sweep_sequencer DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // sequencer model: registers
  logic [sss_pkg::TIMER_W-1:0] r_one_way     = sss_pkg::ONE_WAY_RST;
  logic [sss_pkg::TIMER_W-1:0] r_end_rest    = sss_pkg::END_REST_RST;
  logic [sss_pkg::TIMER_W-1:0] r_detach      = sss_pkg::DETACH_RST;
  logic [sss_pkg::TIMER_W-1:0] r_start_delay = sss_pkg::START_DELAY_RST;
  logic [sss_pkg::HOLD_W-1:0]  r_hold        = sss_pkg::HOLD_RST;

  // sequencer model: state
  sweep_phase_e                m_phase     = ST_IDLE;
  logic [sss_pkg::ANGLE_W-1:0] m_angle     = '0;
  logic [sss_pkg::ANGLE_W-1:0] m_start     = '0;
  logic [sss_pkg::ANGLE_W-1:0] m_target    = sss_pkg::ANGLE_W'(180);
  logic [sss_pkg::SWEEP_W-1:0] m_sweep_t   = '0;
  logic [sss_pkg::TIMER_W-1:0] m_dwell_t   = '0;
  logic [sss_pkg::TIMER_W-1:0] m_stopped_t = '0;
  logic                        m_need_delay = 1'b1;
  logic                        m_attached   = 1'b0;
  logic                        m_was_moving = 1'b0;

  sss_pkg::out_item_t pending_results[$];

  int unsigned cycles;
  int unsigned errors;
  int unsigned n_items, n_results, n_settings;
  int unsigned n_idle, n_sweeping, n_dwelling, n_released;
  int unsigned gap_calm, stall_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [sss_pkg::ANGLE_W-1:0] far_side(
      input logic [sss_pkg::ANGLE_W-1:0] a);
    return (a >= sss_pkg::ANGLE_W'(90)) ? sss_pkg::ANGLE_W'(0) : sss_pkg::ANGLE_W'(180);
  endfunction

  function automatic logic [sss_pkg::DUTY_W-1:0] duty_for(
      input logic [sss_pkg::ANGLE_W-1:0] a);
    int unsigned deg, us;
    deg = (a > 180) ? 180 : a;
    us = 500 + (2000 * deg) / 180;
    return sss_pkg::DUTY_W'((us * 50 * 1023) / 1000000);
  endfunction

  // linear position t ms after the hold, toward the target
  function automatic logic [sss_pkg::ANGLE_W-1:0] interp_angle(
      input logic [sss_pkg::SWEEP_W-1:0] t);
    int unsigned span, dur, step;
    bit down;
    down = m_target < m_start;
    span = down ? m_start - m_target : m_target - m_start;
    dur = (span * r_one_way) / 180;
    if (dur == 0 || t >= dur) return m_target;
    step = (span * t) / dur;
    return down ? sss_pkg::ANGLE_W'(m_start - step) : sss_pkg::ANGLE_W'(m_start + step);
  endfunction

  function automatic bit standstill_met(input bit mv);
    if (!m_need_delay) return 1'b1;
    if (mv) return 1'b0;
    if (m_stopped_t >= r_start_delay) begin
      m_need_delay = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void start_sweep();
    m_start = m_angle;
    if (m_angle == m_target) m_target = far_side(m_angle);
    m_attached = 1'b1;
    m_sweep_t = '0;
    m_phase = ST_SWEEP;
  endfunction

  function automatic sss_pkg::out_item_t advance_sweep(input sss_pkg::in_item_t it);
    logic [sss_pkg::SWEEP_W:0] s_sum;
    logic [sss_pkg::TIMER_W:0] d_sum, q_sum;
    bit mv;
    sss_pkg::out_item_t res;
    mv = it.vehicle_moving;
    s_sum = {1'b0, m_sweep_t} + it.elapsed_ms;
    d_sum = {1'b0, m_dwell_t} + it.elapsed_ms;
    q_sum = {1'b0, m_stopped_t} + it.elapsed_ms;
    m_sweep_t   = s_sum[sss_pkg::SWEEP_W] ? sss_pkg::SWEEP_TIME_MAX
                                          : s_sum[sss_pkg::SWEEP_W-1:0];
    m_dwell_t   = d_sum[sss_pkg::TIMER_W] ? sss_pkg::TIMER_MAX : d_sum[sss_pkg::TIMER_W-1:0];
    m_stopped_t = q_sum[sss_pkg::TIMER_W] ? sss_pkg::TIMER_MAX : q_sum[sss_pkg::TIMER_W-1:0];
    if (mv != m_was_moving) begin
      m_was_moving = mv;
      if (!mv) begin
        m_stopped_t = '0;
        m_need_delay = 1'b1;
      end
    end
    case (m_phase)
      ST_SWEEP: begin
        if (m_sweep_t >= r_hold) begin
          m_angle = interp_angle(m_sweep_t - r_hold);
          m_attached = 1'b1;
          if (m_angle == m_target) begin
            m_phase = ST_DWELL;
            m_dwell_t = '0;
          end
        end else begin
          m_angle = m_start;
        end
      end
      ST_DWELL: begin
        if (m_attached && m_dwell_t >= r_detach) m_attached = 1'b0;
        if (!mv && m_dwell_t >= r_end_rest) begin
          if (standstill_met(mv)) begin
            m_target = far_side(m_angle);
            start_sweep();
          end
        end
      end
      default: begin
        m_phase = ST_IDLE;
        m_attached = 1'b0;
        if (standstill_met(mv)) start_sweep();
      end
    endcase
    res.angle_deg      = m_angle;
    res.pulse_duty     = duty_for(m_angle);
    res.servo_attached = m_attached;
    res.sweep_phase    = m_phase;
    return res;
  endfunction

  // mostly back to back, some short gaps, rare long ones, with calm stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (gap_calm > 0) begin
      gap_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r == 0) gap_calm = $urandom_range(20, 80);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic write_reg(input logic [sss_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sss_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      sss_pkg::REG_ONE_WAY:     r_one_way = val;
      sss_pkg::REG_END_REST:    r_end_rest = val;
      sss_pkg::REG_DETACH:      r_detach = val;
      sss_pkg::REG_START_DELAY: r_start_delay = val;
      sss_pkg::REG_HOLD:        r_hold = val[sss_pkg::HOLD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic push_item(input sss_pkg::in_item_t it, input bit typed,
                           input sss_pkg::out_item_t want);
    int unsigned gap;
    sss_pkg::out_item_t got;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    got = advance_sweep(it);
    pending_results.push_back(typed ? want : got);
    n_items++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // output stall pattern
  always @(posedge clk) begin : stall_gen
    int unsigned r;
    if (stall_left == 0) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(1, 12);
      end else if (r < 85) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(1, 3);
      end else if (r < 95) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(8, 40);
      end else begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(100, 300);
      end
    end else begin
      stall_left--;
    end
  end

  always @(posedge clk) begin : result_check
    sss_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result item with none expected: %h", out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        n_results++;
        if (out_data.angle_deg !== want.angle_deg) begin
          $error("angle_deg: expected %0d, got %0d", want.angle_deg, out_data.angle_deg);
          errors++;
        end
        if (out_data.pulse_duty !== want.pulse_duty) begin
          $error("pulse_duty: expected %0d, got %0d", want.pulse_duty, out_data.pulse_duty);
          errors++;
        end
        if (out_data.servo_attached !== want.servo_attached) begin
          $error("servo_attached: expected %0d, got %0d",
                 want.servo_attached, out_data.servo_attached);
          errors++;
        end
        if (out_data.sweep_phase !== want.sweep_phase) begin
          $error("sweep_phase: expected %0d, got %0d", want.sweep_phase, out_data.sweep_phase);
          errors++;
        end
        case (want.sweep_phase)
          ST_SWEEP: n_sweeping++;
          ST_DWELL: n_dwelling++;
          default:  n_idle++;
        endcase
        if (!want.servo_attached) n_released++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles,
               pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    script_row_t row;
    sss_pkg::in_item_t it;
    logic [sss_pkg::CFG_DATA_W-1:0] ow, er, dt, sd, hd;
    int unsigned n, mv_pm, noise_pct, el_lo, r;
    bit moving_lvl;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // scripted part
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      row = SCRIPT[i];
      if (row.kind == ROW_REG) begin
        if (i == 0 || SCRIPT[i-1].kind != ROW_REG) drain_results();
        write_reg(row.reg_idx, row.reg_val);
        if (i == SCRIPT_LEN - 1 || SCRIPT[i+1].kind != ROW_REG) cfg_we <= 1'b0;
      end else begin
        it.elapsed_ms = row.elapsed;
        it.vehicle_moving = row.moving;
        push_item(it, row.typed, row.want);
      end
    end

    // randomized runs, one register setting each
    for (int k = 0; k < N_SETTINGS; k++) begin
      case (k)
        0: begin
          // longest hold, rest and detach with the slowest sweep, no start delay
          ow = '1; er = '1; dt = '1; sd = '0; hd = '1;
          n = 130; mv_pm = 0; el_lo = 56;
        end
        1: begin
          ow = 16'd1; er = '0; dt = '0; sd = '0; hd = '0;
          n = 80; mv_pm = 150; el_lo = 0;
        end
        N_SETTINGS - 1: begin
          ow = sss_pkg::ONE_WAY_RST; er = sss_pkg::END_REST_RST; dt = sss_pkg::DETACH_RST;
          sd = sss_pkg::START_DELAY_RST; hd = sss_pkg::CFG_DATA_W'(sss_pkg::HOLD_RST);
          n = 120; mv_pm = 5; el_lo = 32;
        end
        default: begin
          ow = sss_pkg::CFG_DATA_W'($urandom_range(1, 600));
          er = sss_pkg::CFG_DATA_W'($urandom_range(0, 300));
          dt = sss_pkg::CFG_DATA_W'($urandom_range(0, 300));
          sd = sss_pkg::CFG_DATA_W'($urandom_range(0, 400));
          hd = sss_pkg::CFG_DATA_W'($urandom_range(0, 80));
          n = 40; mv_pm = 40; el_lo = 0;
        end
      endcase
      noise_pct = (mv_pm != 0) ? 3 : 0;
      drain_results();
      write_reg(sss_pkg::REG_ONE_WAY, ow);
      write_reg(sss_pkg::REG_END_REST, er);
      write_reg(sss_pkg::REG_DETACH, dt);
      write_reg(sss_pkg::REG_START_DELAY, sd);
      write_reg(sss_pkg::REG_HOLD, hd);
      write_reg(sss_pkg::CFG_IDX_W'($urandom_range(sss_pkg::REG_HOLD + 1, REG_UNUSED)),
                sss_pkg::CFG_DATA_W'($urandom));
      cfg_we <= 1'b0;
      n_settings++;
      moving_lvl = 1'b0;
      for (int unsigned j = 0; j < n; j++) begin
        // driving bursts with a little single-item noise on the level
        if (moving_lvl) moving_lvl = ($urandom_range(0, 99) >= 30);
        else moving_lvl = ($urandom_range(0, 999) < mv_pm);
        it.vehicle_moving = moving_lvl ^ ($urandom_range(0, 99) < noise_pct);
        r = $urandom_range(0, 9);
        if (r == 0) it.elapsed_ms = '0;
        else if (r == 1) it.elapsed_ms = sss_pkg::ELAPSED_W'($urandom_range(0, 63));
        else it.elapsed_ms = sss_pkg::ELAPSED_W'($urandom_range(el_lo, 63));
        push_item(it, 1'b0, NO_CHECK);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("ran %0d items under %0d register settings plus a scripted part",
             n_items, n_settings);
    $display("checked %0d results: %0d idle, %0d sweeping, %0d dwelling, %0d released",
             n_results, n_idle, n_sweeping, n_dwelling, n_released);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
